// ===== rtl/core/egvd_pkg.sv =====
// shared types, constants and helpers of the vertex deform core
// no dependencies
`default_nettype none

package egvd_pkg;

    // input item kinds, same codes as the mode field
    typedef enum logic [1:0] {
        MODE_VERTEX    = 2'd0,
        MODE_NODE_WORD = 2'd1,
        MODE_NEIGHBOUR = 2'd2,
        MODE_COMPUTE   = 2'd3
    } t_mode;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_LOCAL_ONLY = 3'd0,
        CFG_ANGLE_X    = 3'd1,
        CFG_ANGLE_Y    = 3'd2,
        CFG_ANGLE_Z    = 3'd3,
        CFG_SHIFT_X    = 3'd4,
        CFG_SHIFT_Y    = 3'd5,
        CFG_SHIFT_Z    = 3'd6
    } t_cfg;

    localparam int AFFINE_WORDS = 12;
    localparam int OFFSET_WORD  = 9;

    localparam logic signed [33:0] PI30        = 34'sd3373259426;
    localparam logic signed [33:0] HALFPI30    = 34'sd1686629713;
    localparam logic signed [33:0] ONE30       = 34'sd1073741824;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    typedef logic [2:0][31:0]      t_vec3;
    typedef logic [2:0][2:0][31:0] t_mat;

    // classified item between front and back
    typedef struct packed {
        t_mode              kind;
        logic [5:0]         idx;
        logic [3:0]         slot;
        logic [5:0]         node;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [16:0]        weight;
    } t_item;

    typedef struct packed {
        logic [5:0]  idx;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } t_result;

    // back side control and status
    typedef struct packed {
        logic q_pop;
        logic out_push;
        logic clearing;
    } t_back_ctl;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fff_ffff;
        end else if (v < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // truncated arctangent table, 30 fraction bits
    function automatic logic signed [33:0] atan30(input logic [4:0] i);
        case (i)
            5'd0:  return 34'sh3243F6A8;
            5'd1:  return 34'sh1DAC6705;
            5'd2:  return 34'sh0FADBAFC;
            5'd3:  return 34'sh07F56EA6;
            5'd4:  return 34'sh03FEAB76;
            5'd5:  return 34'sh01FFD55B;
            5'd6:  return 34'sh00FFFAAA;
            5'd7:  return 34'sh007FFF55;
            5'd8:  return 34'sh003FFFEA;
            5'd9:  return 34'sh001FFFFD;
            5'd10: return 34'sh000FFFFF;
            5'd11: return 34'sh0007FFFF;
            5'd12: return 34'sh0003FFFF;
            5'd13: return 34'sh0001FFFF;
            5'd14: return 34'sh0000FFFF;
            5'd15: return 34'sh00007FFF;
            5'd16: return 34'sh00003FFF;
            5'd17: return 34'sh00001FFF;
            5'd18: return 34'sh00000FFF;
            5'd19: return 34'sh000007FF;
            5'd20: return 34'sh000003FF;
            5'd21: return 34'sh000001FF;
            5'd22: return 34'sh000000FF;
            5'd23: return 34'sh0000007F;
            5'd24: return 34'sh0000003F;
            5'd25: return 34'sh0000001F;
            5'd26: return 34'sh0000000F;
            5'd27: return 34'sh00000007;
            5'd28: return 34'sh00000003;
            5'd29: return 34'sh00000001;
            default: return 34'sh0;
        endcase
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/egvd_fifo.sv =====
// small first-in first-out queue of W-bit beats
// no dependencies
`default_nettype none

module egvd_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_din,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_dout,
    output logic              o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [PW:0]   r_cnt;
    logic          w_we;
    logic          w_re;

    assign o_full  = (r_cnt == (PW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_we    = i_push && !o_full;
    assign w_re    = i_pop && !o_empty;
    assign o_dout  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_wp] <= i_din;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_we) begin
                r_wp <= (r_wp == PW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (w_re) begin
                r_rp <= (r_rp == PW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            if (w_we && !w_re) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_re && !w_we) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/egvd_front.sv =====
// front end: accepts input beats, drops out-of-range beats, queues the rest
// depends on egvd_pkg, egvd_fifo
`default_nettype none

module egvd_front import egvd_pkg::*; #(
    parameter int MAX_VERTICES = 64,
    parameter int NEIGHBOURS   = 4,
    parameter int QDEPTH       = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    output logic                    o_full,
    input  wire logic [1:0]         i_mode,
    input  wire logic [5:0]         i_vertex_index,
    input  wire logic [3:0]         i_slot,
    input  wire logic [5:0]         i_neighbour_node,
    input  wire logic signed [31:0] i_coord_x,
    input  wire logic signed [31:0] i_coord_y,
    input  wire logic signed [31:0] i_coord_z,
    input  wire logic [16:0]        i_blend_weight,
    input  wire logic               i_clearing,
    input  wire logic               i_pop,
    output logic                    o_empty,
    output t_item                   o_item
);

    t_item             w_item;
    logic              w_keep;
    logic              w_idx_ok;
    logic              w_q_full;
    logic [$bits(t_item)-1:0] w_dout;

    always_comb begin
        w_item.kind   = t_mode'(i_mode);
        w_item.idx    = i_vertex_index;
        w_item.slot   = i_slot;
        w_item.node   = i_neighbour_node;
        w_item.x      = i_coord_x;
        w_item.y      = i_coord_y;
        w_item.z      = i_coord_z;
        w_item.weight = i_blend_weight;

        w_idx_ok = (13'(i_vertex_index) < 13'(MAX_VERTICES));
        case (t_mode'(i_mode))
            MODE_NODE_WORD: w_keep = w_idx_ok && (5'(i_slot) < 5'(AFFINE_WORDS));
            MODE_NEIGHBOUR: w_keep = w_idx_ok && (5'(i_slot) < 5'(NEIGHBOURS));
            default:        w_keep = w_idx_ok;
        endcase
    end

    // no beat taken during the slot clearing pass
    assign o_full = w_q_full || i_clearing;

    egvd_fifo #(
        .W     ($bits(t_item)),
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push && !o_full && w_keep),
        .i_din   (w_item),
        .o_full  (w_q_full),
        .i_pop   (i_pop),
        .o_dout  (w_dout),
        .o_empty (o_empty)
    );

    assign o_item = t_item'(w_dout);

endmodule

`default_nettype wire

// ===== rtl/core/egvd_rot.sv =====
// global rotation matrix builder: three cordic lanes, then a shared multiplier
// depends on egvd_pkg
`default_nettype none

module egvd_rot import egvd_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [18:0] i_angle_x,
    input  wire logic signed [18:0] i_angle_y,
    input  wire logic signed [18:0] i_angle_z,
    output logic                    o_valid,
    output t_mat                    o_mat
);

    typedef enum logic [2:0] {R_INIT, R_CORD, R_MUL, R_CLAMP, R_DONE} t_rstate;
    typedef enum logic [1:0] {OP_SET, OP_ADD, OP_SUB} t_op;

    localparam int LX = 0;
    localparam int LY = 1;
    localparam int LZ = 2;
    localparam logic [3:0] D_PA = 4'd9;
    localparam logic [3:0] D_PB = 4'd10;

    t_rstate            r_state;
    logic [4:0]         r_it;
    logic [3:0]         r_step;
    logic signed [33:0] r_x [3];
    logic signed [33:0] r_y [3];
    logic signed [33:0] r_a [3];
    logic               r_neg [3];
    logic signed [33:0] r_e [9];
    logic signed [33:0] r_pa;
    logic signed [33:0] r_pb;
    t_mat               r_mat;

    logic signed [33:0] w_ang [3];
    logic signed [31:0] w_sn [3];
    logic signed [31:0] w_cs [3];
    logic signed [33:0] w_nx [3];
    logic signed [33:0] w_ny [3];
    logic signed [33:0] w_na [3];
    logic signed [33:0] w_negx;
    logic signed [31:0] w_opa;
    logic signed [31:0] w_opb;
    logic [3:0]         w_dst;
    t_op                w_op;
    logic signed [63:0] w_prod;
    logic signed [33:0] w_m;

    function automatic logic [31:0] clamp30(input logic signed [33:0] v);
        if (v > ONE30) begin
            return 32'(ONE30);
        end else if (v < -ONE30) begin
            return 32'(-ONE30);
        end
        return v[31:0];
    endfunction

    always_comb begin
        w_ang[LX] = 34'(i_angle_x) <<< 14;
        w_ang[LY] = 34'(i_angle_y) <<< 14;
        w_ang[LZ] = 34'(i_angle_z) <<< 14;
        w_negx = '0;
        for (int l = 0; l < 3; l++) begin
            // one micro-rotation per lane
            if (r_a[l] >= 0) begin
                w_nx[l] = r_x[l] - (r_y[l] >>> r_it);
                w_ny[l] = r_y[l] + (r_x[l] >>> r_it);
                w_na[l] = r_a[l] - atan30(r_it);
            end else begin
                w_nx[l] = r_x[l] + (r_y[l] >>> r_it);
                w_ny[l] = r_y[l] - (r_x[l] >>> r_it);
                w_na[l] = r_a[l] + atan30(r_it);
            end
            w_negx   = -r_x[l];
            w_sn[l]  = r_y[l][31:0];
            w_cs[l]  = r_neg[l] ? w_negx[31:0] : r_x[l][31:0];
        end
    end

    // product schedule of the matrix entries
    always_comb begin
        w_opa = w_cs[LY];
        w_opb = w_cs[LZ];
        w_dst = 4'd0;
        w_op  = OP_SET;
        case (r_step)
            4'd0:  begin w_opa = w_cs[LY]; w_opb = w_cs[LZ]; w_dst = 4'd0; w_op = OP_SET; end
            4'd1:  begin w_opa = w_cs[LY]; w_opb = w_sn[LZ]; w_dst = 4'd1; w_op = OP_SET; end
            4'd2:  begin w_opa = w_sn[LX]; w_opb = w_sn[LY]; w_dst = D_PA; w_op = OP_SET; end
            4'd3:  begin w_opa = w_cs[LX]; w_opb = w_sn[LY]; w_dst = D_PB; w_op = OP_SET; end
            4'd4:  begin w_opa = r_pa[31:0]; w_opb = w_cs[LZ]; w_dst = 4'd3; w_op = OP_SET; end
            4'd5:  begin w_opa = w_cs[LX]; w_opb = w_sn[LZ]; w_dst = 4'd3; w_op = OP_SUB; end
            4'd6:  begin w_opa = r_pa[31:0]; w_opb = w_sn[LZ]; w_dst = 4'd4; w_op = OP_SET; end
            4'd7:  begin w_opa = w_cs[LX]; w_opb = w_cs[LZ]; w_dst = 4'd4; w_op = OP_ADD; end
            4'd8:  begin w_opa = r_pb[31:0]; w_opb = w_cs[LZ]; w_dst = 4'd6; w_op = OP_SET; end
            4'd9:  begin w_opa = w_sn[LX]; w_opb = w_sn[LZ]; w_dst = 4'd6; w_op = OP_ADD; end
            4'd10: begin w_opa = r_pb[31:0]; w_opb = w_sn[LZ]; w_dst = 4'd7; w_op = OP_SET; end
            4'd11: begin w_opa = w_sn[LX]; w_opb = w_cs[LZ]; w_dst = 4'd7; w_op = OP_SUB; end
            4'd12: begin w_opa = w_sn[LX]; w_opb = w_cs[LY]; w_dst = 4'd5; w_op = OP_SET; end
            4'd13: begin w_opa = w_cs[LX]; w_opb = w_cs[LY]; w_dst = 4'd8; w_op = OP_SET; end
            default: begin w_opa = w_cs[LY]; w_opb = w_cs[LZ]; w_dst = 4'd0; w_op = OP_SET; end
        endcase
        w_prod = w_opa * w_opb;
        w_m    = 34'((w_prod + 64'sd536870912) >>> 30);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= R_INIT;
            r_it    <= '0;
            r_step  <= '0;
        end else if (i_start) begin
            r_state <= R_INIT;
        end else begin
            case (r_state)
                R_INIT: begin
                    for (int l = 0; l < 3; l++) begin
                        r_x[l] <= CORDIC_GAIN;
                        r_y[l] <= '0;
                        // fold into the right half plane, cosine flips sign
                        if (w_ang[l] > HALFPI30) begin
                            r_a[l]   <= PI30 - w_ang[l];
                            r_neg[l] <= 1'b1;
                        end else if (w_ang[l] < -HALFPI30) begin
                            r_a[l]   <= -PI30 - w_ang[l];
                            r_neg[l] <= 1'b1;
                        end else begin
                            r_a[l]   <= w_ang[l];
                            r_neg[l] <= 1'b0;
                        end
                    end
                    r_it    <= '0;
                    r_state <= R_CORD;
                end
                R_CORD: begin
                    for (int l = 0; l < 3; l++) begin
                        r_x[l] <= w_nx[l];
                        r_y[l] <= w_ny[l];
                        r_a[l] <= w_na[l];
                    end
                    r_it <= r_it + 1'b1;
                    if (r_it == 5'd29) begin
                        r_step  <= '0;
                        r_state <= R_MUL;
                    end
                end
                R_MUL: begin
                    if (w_dst == D_PA) begin
                        r_pa <= w_m;
                    end else if (w_dst == D_PB) begin
                        r_pb <= w_m;
                    end else begin
                        case (w_op)
                            OP_ADD:  r_e[w_dst] <= r_e[w_dst] + w_m;
                            OP_SUB:  r_e[w_dst] <= r_e[w_dst] - w_m;
                            default: r_e[w_dst] <= w_m;
                        endcase
                    end
                    r_step <= r_step + 1'b1;
                    if (r_step == 4'd13) begin
                        r_state <= R_CLAMP;
                    end
                end
                R_CLAMP: begin
                    for (int r = 0; r < 3; r++) begin
                        for (int c = 0; c < 3; c++) begin
                            // top right entry is minus sine of y
                            if (r == 0 && c == 2) begin
                                r_mat[r][c] <= clamp30(-34'(w_sn[LY]));
                            end else begin
                                r_mat[r][c] <= clamp30(r_e[r*3+c]);
                            end
                        end
                    end
                    r_state <= R_DONE;
                end
                default: r_state <= R_DONE;
            endcase
        end
    end

    assign o_valid = (r_state == R_DONE);
    assign o_mat   = r_mat;

endmodule

`default_nettype wire

// ===== rtl/core/egvd_back.sv =====
// back end: vertex, affine and slot stores plus the deform sequencer
// depends on egvd_pkg
`default_nettype none

module egvd_back import egvd_pkg::*; #(
    parameter int MAX_VERTICES = 64,
    parameter int NEIGHBOURS   = 4,
    parameter int FRAC_BITS    = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_q_empty,
    input  wire t_item i_q_item,
    input  wire logic  i_local_only,
    input  wire t_vec3 i_shift,
    input  wire logic  i_mat_valid,
    input  wire t_mat  i_mat,
    input  wire logic  i_out_full,
    output t_back_ctl  o_ctl,
    output t_result    o_result
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int SW = (NEIGHBOURS > 1) ? $clog2(NEIGHBOURS) : 1;
    localparam logic signed [63:0] RND_F = 64'sd1 <<< (FRAC_BITS - 1);

    typedef struct packed {
        logic [5:0]  node;
        logic [16:0] weight;
    } t_slot;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_CAP_I, ST_SLOT, ST_CAP_J, ST_MAC, ST_ADDV,
        ST_ADDB, ST_WGT, ST_LOC, ST_WAITM, ST_ROT, ST_FIN, ST_PUSH
    } t_state;

    // stores
    logic [31:0] r_vmem [3][MAX_VERTICES];
    logic [31:0] r_amem [AFFINE_WORDS][MAX_VERTICES];
    t_slot       r_smem [NEIGHBOURS][MAX_VERTICES];

    logic signed [31:0] r_vq [3];
    logic signed [31:0] r_aq [AFFINE_WORDS];
    t_slot              r_sq [NEIGHBOURS];

    t_state             r_state;
    logic [AW-1:0]      r_clr_addr;
    logic [SW-1:0]      r_k;
    logic [1:0]         r_r;
    logic [5:0]         r_idx;
    logic signed [31:0] r_vi [3];
    logic signed [31:0] r_d [3];
    logic signed [63:0] r_t [3];
    logic signed [63:0] r_acc [3];
    logic signed [31:0] r_loc [3];
    logic signed [63:0] r_s [3];
    logic signed [31:0] r_res [3];

    logic               w_pop;
    logic               w_comp;
    logic               w_take;
    logic               w_last;
    logic               w_vre;
    logic               w_are;
    logic               w_sre;
    logic [AW-1:0]      w_qaddr;
    logic [AW-1:0]      w_raddr;
    logic [12:0]        w_ext;
    t_slot              w_sl;
    logic [3:0]         w_aidx [3];
    logic signed [63:0] w_mac [3];
    logic signed [63:0] w_wp [3];
    logic signed [63:0] w_rp [3];

    always_comb begin
        w_pop   = (r_state == ST_IDLE) && !i_q_empty;
        w_comp  = (i_q_item.kind == MODE_COMPUTE);
        w_ext   = 13'(i_q_item.idx);
        w_qaddr = w_ext[AW-1:0];
        w_sl    = r_sq[r_k];
        // empty slots and out-of-range nodes are skipped
        w_take  = (w_sl.weight != '0) && (13'(w_sl.node) < 13'(MAX_VERTICES));
        w_last  = (r_k == SW'(NEIGHBOURS - 1));
        w_vre   = (w_pop && w_comp) || ((r_state == ST_SLOT) && w_take);
        w_are   = (r_state == ST_SLOT) && w_take;
        w_sre   = w_pop && w_comp;
        w_ext   = 13'(w_sl.node);
        w_raddr = (r_state == ST_SLOT) ? w_ext[AW-1:0] : w_qaddr;
        for (int c = 0; c < 3; c++) begin
            w_aidx[c] = 4'(r_r) * 4'd3 + 4'(c);
            w_mac[c]  = (64'(r_d[r_r] * r_aq[w_aidx[c]]) + RND_F) >>> FRAC_BITS;
            w_wp[c]   = (64'($signed(r_t[c][31:0]) * $signed({1'b0, w_sl.weight})) + RND_F)
                        >>> FRAC_BITS;
            w_rp[c]   = r_loc[r_r] * $signed(i_mat[r_r][c]);
        end
    end

    // store writes: loads from the queue, or the clearing pass
    always_ff @(posedge i_clk) begin
        if (w_pop && (i_q_item.kind == MODE_VERTEX)) begin
            r_vmem[0][w_qaddr] <= i_q_item.x;
            r_vmem[1][w_qaddr] <= i_q_item.y;
            r_vmem[2][w_qaddr] <= i_q_item.z;
        end
        for (int w = 0; w < AFFINE_WORDS; w++) begin
            if (w_pop && (i_q_item.kind == MODE_NODE_WORD) && (i_q_item.slot == 4'(w))) begin
                r_amem[w][w_qaddr] <= i_q_item.x;
            end
        end
        for (int k = 0; k < NEIGHBOURS; k++) begin
            if (r_state == ST_CLEAR) begin
                r_smem[k][r_clr_addr] <= '0;
            end else if (w_pop && (i_q_item.kind == MODE_NEIGHBOUR) &&
                         (i_q_item.slot == 4'(k))) begin
                r_smem[k][w_qaddr] <= '{node: i_q_item.node, weight: i_q_item.weight};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_vre) begin
            for (int c = 0; c < 3; c++) begin
                r_vq[c] <= r_vmem[c][w_raddr];
            end
        end
        if (w_are) begin
            for (int w = 0; w < AFFINE_WORDS; w++) begin
                r_aq[w] <= r_amem[w][w_raddr];
            end
        end
        if (w_sre) begin
            for (int k = 0; k < NEIGHBOURS; k++) begin
                r_sq[k] <= r_smem[k][w_raddr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_k        <= '0;
            r_r        <= '0;
        end else begin
            case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == AW'(MAX_VERTICES - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (w_pop && w_comp) begin
                        r_idx   <= i_q_item.idx;
                        r_state <= ST_CAP_I;
                    end
                end
                ST_CAP_I: begin
                    for (int c = 0; c < 3; c++) begin
                        r_vi[c]  <= r_vq[c];
                        r_acc[c] <= '0;
                    end
                    r_k     <= '0;
                    r_state <= ST_SLOT;
                end
                ST_SLOT: begin
                    if (w_take) begin
                        r_state <= ST_CAP_J;
                    end else if (w_last) begin
                        r_state <= ST_LOC;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                ST_CAP_J: begin
                    for (int c = 0; c < 3; c++) begin
                        r_d[c] <= sat32(64'(r_vi[c]) - 64'(r_vq[c]));
                        r_t[c] <= '0;
                    end
                    r_r     <= '0;
                    r_state <= ST_MAC;
                end
                ST_MAC: begin
                    for (int c = 0; c < 3; c++) begin
                        r_t[c] <= r_t[c] + w_mac[c];
                    end
                    r_r <= r_r + 1'b1;
                    if (r_r == 2'd2) begin
                        r_state <= ST_ADDV;
                    end
                end
                ST_ADDV: begin
                    for (int c = 0; c < 3; c++) begin
                        r_t[c] <= 64'(sat32(64'(sat32(r_t[c])) + 64'(r_vq[c])));
                    end
                    r_state <= ST_ADDB;
                end
                ST_ADDB: begin
                    for (int c = 0; c < 3; c++) begin
                        r_t[c] <= 64'(sat32(r_t[c] + 64'(r_aq[OFFSET_WORD + c])));
                    end
                    r_state <= ST_WGT;
                end
                ST_WGT: begin
                    for (int c = 0; c < 3; c++) begin
                        r_acc[c] <= r_acc[c] + w_wp[c];
                    end
                    if (w_last) begin
                        r_state <= ST_LOC;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= ST_SLOT;
                    end
                end
                ST_LOC: begin
                    for (int c = 0; c < 3; c++) begin
                        r_res[c] <= sat32(r_acc[c]);
                        r_loc[c] <= sat32(r_acc[c]);
                        r_s[c]   <= '0;
                    end
                    r_r     <= '0;
                    r_state <= i_local_only ? ST_PUSH : ST_WAITM;
                end
                ST_WAITM: begin
                    if (i_mat_valid) begin
                        r_state <= ST_ROT;
                    end
                end
                ST_ROT: begin
                    for (int c = 0; c < 3; c++) begin
                        r_s[c] <= r_s[c] + w_rp[c];
                    end
                    r_r <= r_r + 1'b1;
                    if (r_r == 2'd2) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    for (int c = 0; c < 3; c++) begin
                        r_res[c] <= sat32(((r_s[c] + 64'sd536870912) >>> 30)
                                          + 64'($signed(i_shift[c])));
                    end
                    r_state <= ST_PUSH;
                end
                ST_PUSH: begin
                    if (!i_out_full) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_ctl.q_pop    = w_pop;
    assign o_ctl.out_push = (r_state == ST_PUSH) && !i_out_full;
    assign o_ctl.clearing = (r_state == ST_CLEAR);
    assign o_result.idx   = r_idx;
    assign o_result.x     = r_res[0];
    assign o_result.y     = r_res[1];
    assign o_result.z     = r_res[2];

endmodule

`default_nettype wire

// ===== rtl/core/embedded_graph_vertex_deform_core.sv =====
// top level of the embedded deformation graph vertex deform core
// depends on egvd_pkg, egvd_fifo, egvd_front, egvd_rot, egvd_back
//
//  channel  | direction | handshake            | beat
//  ---------+-----------+----------------------+------------------------------------------
//  input    | in        | push / full          | mode, vertex_index, slot, node, coords, w
//  result   | out       | pop / empty          | out_index, out_x, out_y, out_z
//  config   | in        | i_cfg_we (no stall)  | i_cfg_addr, i_cfg_data
//
//  load beats go straight into the stores while the back end is idle; a compute beat visits
//  each neighbour slot in turn, skipping empty ones, with a three-lane multiply-accumulate
//  over the matrix rows of each used node; unless local_only is set it then rotates and shifts
//  after reset the slot stores are swept, one address at a time, with full held high
//  the rotation matrix is rebuilt after reset and after any angle write;
//  a compute beat waits for it at its rotation step
//  a four-beat queue parts front and back, a two-beat queue holds finished results
`default_nettype none

module embedded_graph_vertex_deform_core import egvd_pkg::*; #(
    parameter int MAX_VERTICES = 64,
    parameter int NEIGHBOURS   = 4,
    parameter int FRAC_BITS    = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [1:0]         i_mode,
    input  wire logic [5:0]         i_vertex_index,
    input  wire logic [3:0]         i_slot,
    input  wire logic [5:0]         i_neighbour_node,
    input  wire logic signed [31:0] i_coord_x,
    input  wire logic signed [31:0] i_coord_y,
    input  wire logic signed [31:0] i_coord_z,
    input  wire logic [16:0]        i_blend_weight,
    output logic                    empty,
    input  wire logic               pop,
    output logic [5:0]              o_out_index,
    output logic signed [31:0]      o_out_x,
    output logic signed [31:0]      o_out_y,
    output logic signed [31:0]      o_out_z,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_addr,
    input  wire logic [31:0]        i_cfg_data
);

    // configuration registers
    logic               r_local_only;
    logic signed [18:0] r_angle_x;
    logic signed [18:0] r_angle_y;
    logic signed [18:0] r_angle_z;
    t_vec3              r_shift;

    logic        w_angle_wr;
    logic        w_q_empty;
    t_item       w_q_item;
    t_back_ctl   w_ctl;
    t_result     w_result;
    logic        w_mat_valid;
    t_mat        w_mat;
    logic        w_out_full;
    logic [$bits(t_result)-1:0] w_out_dout;
    t_result     w_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_only <= 1'b0;
            r_angle_x    <= '0;
            r_angle_y    <= '0;
            r_angle_z    <= '0;
            r_shift      <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg'(i_cfg_addr))
                CFG_LOCAL_ONLY: r_local_only <= i_cfg_data[0];
                CFG_ANGLE_X:    r_angle_x    <= i_cfg_data[18:0];
                CFG_ANGLE_Y:    r_angle_y    <= i_cfg_data[18:0];
                CFG_ANGLE_Z:    r_angle_z    <= i_cfg_data[18:0];
                CFG_SHIFT_X:    r_shift[0]   <= i_cfg_data;
                CFG_SHIFT_Y:    r_shift[1]   <= i_cfg_data;
                CFG_SHIFT_Z:    r_shift[2]   <= i_cfg_data;
                default:        ;
            endcase
        end
    end

    // any angle write restarts the matrix build
    assign w_angle_wr = i_cfg_we && ((t_cfg'(i_cfg_addr) == CFG_ANGLE_X) ||
                                     (t_cfg'(i_cfg_addr) == CFG_ANGLE_Y) ||
                                     (t_cfg'(i_cfg_addr) == CFG_ANGLE_Z));

    // front: classify and queue input beats
    egvd_front #(
        .MAX_VERTICES (MAX_VERTICES),
        .NEIGHBOURS   (NEIGHBOURS),
        .QDEPTH       (4)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .o_full           (full),
        .i_mode           (i_mode),
        .i_vertex_index   (i_vertex_index),
        .i_slot           (i_slot),
        .i_neighbour_node (i_neighbour_node),
        .i_coord_x        (i_coord_x),
        .i_coord_y        (i_coord_y),
        .i_coord_z        (i_coord_z),
        .i_blend_weight   (i_blend_weight),
        .i_clearing       (w_ctl.clearing),
        .i_pop            (w_ctl.q_pop),
        .o_empty          (w_q_empty),
        .o_item           (w_q_item)
    );

    // rotation matrix from the euler angles
    egvd_rot u_rot (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_angle_wr),
        .i_angle_x (r_angle_x),
        .i_angle_y (r_angle_y),
        .i_angle_z (r_angle_z),
        .o_valid   (w_mat_valid),
        .o_mat     (w_mat)
    );

    // back: stores and deform sequencer
    egvd_back #(
        .MAX_VERTICES (MAX_VERTICES),
        .NEIGHBOURS   (NEIGHBOURS),
        .FRAC_BITS    (FRAC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (w_q_empty),
        .i_q_item     (w_q_item),
        .i_local_only (r_local_only),
        .i_shift      (r_shift),
        .i_mat_valid  (w_mat_valid),
        .i_mat        (w_mat),
        .i_out_full   (w_out_full),
        .o_ctl        (w_ctl),
        .o_result     (w_result)
    );

    // result queue, lets the sequencer move on while a beat waits for pop
    egvd_fifo #(
        .W     ($bits(t_result)),
        .DEPTH (2)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_ctl.out_push),
        .i_din   (w_result),
        .o_full  (w_out_full),
        .i_pop   (pop),
        .o_dout  (w_out_dout),
        .o_empty (empty)
    );

    assign w_out       = t_result'(w_out_dout);
    assign o_out_index = w_out.idx;
    assign o_out_x     = w_out.x;
    assign o_out_y     = w_out.y;
    assign o_out_z     = w_out.z;

    // a finished result is never offered to a full result queue
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.out_push |-> !w_out_full)
        else $error("result pushed into full queue");

    // input side is closed for the whole clearing sweep
    a_full_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.clearing |-> full)
        else $error("input open during slot clearing");

    // an angle write invalidates the matrix
    a_angle_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_angle_wr |=> !w_mat_valid)
        else $error("stale rotation matrix after angle write");

endmodule

`default_nettype wire

// ===== tb/egvd_deform_checker.sv =====
// checker for the vertex deform core: watches load, compute, config and result beats,
// predicts each deformed vertex and compares it with what comes out
// depends on egvd_pkg (mode and register codes, result type)
`default_nettype none

module egvd_deform_checker import egvd_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    input  wire logic        full,
    input  wire logic [1:0]  i_mode,
    input  wire logic [5:0]  i_vertex_index,
    input  wire logic [3:0]  i_slot,
    input  wire logic [5:0]  i_neighbour_node,
    input  wire logic [31:0] i_coord_x,
    input  wire logic [31:0] i_coord_y,
    input  wire logic [31:0] i_coord_z,
    input  wire logic [16:0] i_blend_weight,
    input  wire logic        empty,
    input  wire logic        pop,
    input  wire logic [5:0]  i_out_index,
    input  wire logic [31:0] i_out_x,
    input  wire logic [31:0] i_out_y,
    input  wire logic [31:0] i_out_z,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_addr,
    input  wire logic [31:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_awaiting
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NV = 64;
    localparam int NK = 4;
    localparam int FB = 16;

    localparam longint ARCTAN [30] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
        64'h0000001F, 64'h0000000F, 64'h00000007, 64'h00000003, 64'h00000001
    };

    logic [31:0] pos_mem  [NV][3];
    logic [31:0] word_mem [NV][12];
    logic [5:0]  link_node[NV][NK];
    logic [16:0] link_w   [NV][NK];
    logic        only_local;
    logic [18:0] ang_x, ang_y, ang_z;
    logic [31:0] shf_x, shf_y, shf_z;

    t_result expected_points[$];

    assign o_awaiting = expected_points.size();

    function automatic longint round_shift(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint clip30(longint v);
        if (v > 64'sd1073741824) return 64'sd1073741824;
        if (v < -64'sd1073741824) return -64'sd1073741824;
        return v;
    endfunction

    function automatic longint s32(logic [31:0] v);
        return longint'($signed(v));
    endfunction

    function automatic longint mul30(longint a, longint b);
        return round_shift(a * b, 30);
    endfunction

    // cordic sine and cosine, result at 30 fraction bits
    task automatic sine_cosine(input logic [18:0] ang, output longint s, output longint c);
        longint a, x, y, t;
        bit flip;
        a = longint'($signed(ang)) * 16384;
        flip = 0;
        x = 64'h26DD3B6A;
        y = 0;
        if (a > 64'sd1686629713) begin
            a = 64'sd3373259426 - a;
            flip = 1;
        end else if (a < -64'sd1686629713) begin
            a = -64'sd3373259426 - a;
            flip = 1;
        end
        for (int i = 0; i < 30; i++) begin
            if (a >= 0) begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                a = a - ARCTAN[i];
            end else begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                a = a + ARCTAN[i];
            end
            x = t;
        end
        s = y;
        c = flip ? -x : x;
    endtask

    task automatic deform_vertex(input logic [5:0] vi, output t_result r);
        longint own[3], acc[3], loc[3], res[3], d[3], vj[3], shf[3];
        longint sx, cx, sy, cy, sz, cz, t, sum;
        longint rot[3][3];
        int j;
        for (int c = 0; c < 3; c++) begin
            own[c] = s32(pos_mem[vi][c]);
            acc[c] = 0;
        end
        for (int k = 0; k < NK; k++) begin
            j = link_node[vi][k];
            if (link_w[vi][k] != 0) begin
                for (int c = 0; c < 3; c++) begin
                    vj[c] = s32(pos_mem[j][c]);
                    d[c] = clip32(own[c] - vj[c]);
                end
                for (int c = 0; c < 3; c++) begin
                    t = 0;
                    for (int q = 0; q < 3; q++)
                        t += round_shift(d[q] * s32(word_mem[j][q * 3 + c]), FB);
                    t = clip32(t);
                    t = clip32(t + vj[c]);
                    t = clip32(t + s32(word_mem[j][9 + c]));
                    acc[c] += round_shift(t * longint'(link_w[vi][k]), FB);
                end
            end
        end
        for (int c = 0; c < 3; c++)
            loc[c] = clip32(acc[c]);
        if (only_local) begin
            res = loc;
        end else begin
            sine_cosine(ang_x, sx, cx);
            sine_cosine(ang_y, sy, cy);
            sine_cosine(ang_z, sz, cz);
            rot[0][0] = mul30(cy, cz);
            rot[0][1] = mul30(cy, sz);
            rot[0][2] = -sy;
            rot[1][0] = mul30(mul30(sx, sy), cz) - mul30(cx, sz);
            rot[1][1] = mul30(mul30(sx, sy), sz) + mul30(cx, cz);
            rot[1][2] = mul30(sx, cy);
            rot[2][0] = mul30(mul30(cx, sy), cz) + mul30(sx, sz);
            rot[2][1] = mul30(mul30(cx, sy), sz) - mul30(sx, cz);
            rot[2][2] = mul30(cx, cy);
            shf[0] = s32(shf_x);
            shf[1] = s32(shf_y);
            shf[2] = s32(shf_z);
            for (int c = 0; c < 3; c++) begin
                sum = 0;
                for (int q = 0; q < 3; q++)
                    sum += loc[q] * clip30(rot[q][c]);
                res[c] = clip32(round_shift(sum, 30) + shf[c]);
            end
        end
        r.idx = vi;
        r.x = res[0][31:0];
        r.y = res[1][31:0];
        r.z = res[2][31:0];
    endtask

    task automatic field_check(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            o_fail_count++;
        end
    endtask

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        t_result r;
        if (!i_rst_n) begin
            only_local <= 0;
            ang_x <= 0; ang_y <= 0; ang_z <= 0;
            shf_x <= 0; shf_y <= 0; shf_z <= 0;
            for (int v = 0; v < NV; v++)
                for (int k = 0; k < NK; k++) begin
                    link_node[v][k] = 0;
                    link_w[v][k] = 0;
                end
        end else begin
            if (i_cfg_we) begin
                case (t_cfg'(i_cfg_addr))
                    CFG_LOCAL_ONLY: only_local <= i_cfg_data[0];
                    CFG_ANGLE_X:    ang_x <= i_cfg_data[18:0];
                    CFG_ANGLE_Y:    ang_y <= i_cfg_data[18:0];
                    CFG_ANGLE_Z:    ang_z <= i_cfg_data[18:0];
                    CFG_SHIFT_X:    shf_x <= i_cfg_data;
                    CFG_SHIFT_Y:    shf_y <= i_cfg_data;
                    CFG_SHIFT_Z:    shf_z <= i_cfg_data;
                    default: ;
                endcase
            end
            if (push && !full) begin
                case (t_mode'(i_mode))
                    MODE_VERTEX: begin
                        pos_mem[i_vertex_index][0] = i_coord_x;
                        pos_mem[i_vertex_index][1] = i_coord_y;
                        pos_mem[i_vertex_index][2] = i_coord_z;
                    end
                    MODE_NODE_WORD: begin
                        if (i_slot < 12)
                            word_mem[i_vertex_index][i_slot] = i_coord_x;
                    end
                    MODE_NEIGHBOUR: begin
                        if (i_slot < NK) begin
                            link_node[i_vertex_index][i_slot] = i_neighbour_node;
                            link_w[i_vertex_index][i_slot] = i_blend_weight;
                        end
                    end
                    default: begin
                        deform_vertex(i_vertex_index, r);
                        expected_points.push_back(r);
                    end
                endcase
            end
            if (pop && !empty) begin
                if (expected_points.size() == 0) begin
                    $display("%0t: unexpected result beat, actual index %0d", $time,
                             i_out_index);
                    o_fail_count++;
                end else begin
                    r = expected_points.pop_front();
                    field_check("out_index", 32'(r.idx), 32'(i_out_index));
                    field_check("out_x", r.x, i_out_x);
                    field_check("out_y", r.y, i_out_y);
                    field_check("out_z", r.z, i_out_z);
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== tb/embedded_graph_vertex_deform_core_test.sv =====
// stimulus and verdict for the vertex deform core
// depends on egvd_pkg, the core and egvd_deform_checker
`default_nettype none

module embedded_graph_vertex_deform_core_test import egvd_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NV = 64;
    localparam int NK = 4;
    // slowest compute uses every neighbour slot and waits for the rotation rebuild; generous drain
    localparam int DRAIN = 300;
    localparam longint LIMIT = 1000000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        push = 0;
    logic        full;
    logic [1:0]  mode_q = 0;
    logic [5:0]  vidx_q = 0;
    logic [3:0]  slot_q = 0;
    logic [5:0]  node_q = 0;
    logic [31:0] cx_q = 0, cy_q = 0, cz_q = 0;
    logic [16:0] w_q = 0;
    logic        empty;
    logic        pop = 0;
    logic [5:0]  out_index;
    logic [31:0] out_x, out_y, out_z;
    logic        cfg_we = 0;
    logic [2:0]  cfg_addr = 0;
    logic [31:0] cfg_data = 0;
    int          fail_count, awaiting;

    int     tx_idle_pct = 0;
    int     rx_stall_pct = 0;
    longint cycles = 0;

    // what has been written so far, so no compute ever reads an unwritten entry
    bit          pos_known [NV];
    bit          word_known[NV][12];
    logic [5:0]  tb_node[NV][NK];
    logic [16:0] tb_w   [NV][NK];

    always #2 i_clk = ~i_clk;

    embedded_graph_vertex_deform_core i_dut (
        .i_clk, .i_rst_n, .push, .full,
        .i_mode(mode_q), .i_vertex_index(vidx_q), .i_slot(slot_q),
        .i_neighbour_node(node_q), .i_coord_x(cx_q), .i_coord_y(cy_q),
        .i_coord_z(cz_q), .i_blend_weight(w_q),
        .empty, .pop, .o_out_index(out_index), .o_out_x(out_x), .o_out_y(out_y),
        .o_out_z(out_z), .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr), .i_cfg_data(cfg_data)
    );

    egvd_deform_checker i_checker (
        .i_clk, .i_rst_n, .push, .full,
        .i_mode(mode_q), .i_vertex_index(vidx_q), .i_slot(slot_q),
        .i_neighbour_node(node_q), .i_coord_x(cx_q), .i_coord_y(cy_q),
        .i_coord_z(cz_q), .i_blend_weight(w_q),
        .empty, .pop, .i_out_index(out_index), .i_out_x(out_x), .i_out_y(out_y),
        .i_out_z(out_z), .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_awaiting(awaiting)
    );

    // result side: pop stalls at the phase's rate
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n)
            pop <= ($urandom_range(99) >= rx_stall_pct);
    end

    // watchdog
    always @(posedge i_clk) begin
        if (cycles > LIMIT) begin
            $display("embedded_graph_vertex_deform_core verification failed");
            $finish;
        end
    end

    // one input beat, with random idle cycles ahead of it
    task automatic send_beat(t_mode m, logic [5:0] vi, logic [3:0] sl, logic [5:0] nd,
                             logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             logic [16:0] w);
        while ($urandom_range(99) < tx_idle_pct) begin
            push <= 0;
            @(posedge i_clk);
        end
        push <= 1;
        mode_q <= m;
        vidx_q <= vi;
        slot_q <= sl;
        node_q <= nd;
        cx_q <= x;
        cy_q <= y;
        cz_q <= z;
        w_q <= w;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        // mirror what the block now holds
        case (m)
            MODE_VERTEX:    pos_known[vi] = 1;
            MODE_NODE_WORD: if (sl < 12) word_known[vi][sl] = 1;
            MODE_NEIGHBOUR: if (sl < NK) begin
                tb_node[vi][sl] = nd;
                tb_w[vi][sl] = w;
            end
            default: ;
        endcase
    endtask

    function automatic bit node_ready(logic [5:0] n);
        if (!pos_known[n])
            return 0;
        for (int i = 0; i < 12; i++)
            if (!word_known[n][i])
                return 0;
        return 1;
    endfunction

    function automatic bit can_compute(logic [5:0] v);
        if (!pos_known[v])
            return 0;
        for (int k = 0; k < NK; k++)
            if (tb_w[v][k] != 0 && !node_ready(tb_node[v][k]))
                return 0;
        return 1;
    endfunction

    // coordinates: mostly small, some full range, some at the rails
    function automatic logic [31:0] rand_coord();
        int sel;
        sel = $urandom_range(99);
        if (sel < 55)
            return 32'($signed($urandom_range(524288)) - 262144);
        if (sel < 80)
            return $urandom;
        case ($urandom_range(3))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            default: return 32'hffff_ffff;
        endcase
    endfunction

    function automatic logic [31:0] rand_word(logic [3:0] sl);
        if ($urandom_range(9) == 0)
            return rand_coord();
        // mostly near identity so sums stay inside the rails
        if (sl == 0 || sl == 4 || sl == 8)
            return 32'(65536 + $signed($urandom_range(16384)) - 8192);
        if (sl >= OFFSET_WORD)
            return 32'($signed($urandom_range(131072)) - 65536);
        return 32'($signed($urandom_range(16384)) - 8192);
    endfunction

    function automatic logic [16:0] rand_weight();
        case ($urandom_range(7))
            0: return 17'd0;
            1: return 17'd65536;
            2: return 17'd1;
            default: return 17'($urandom_range(65536));
        endcase
    endfunction

    task automatic write_reg(t_cfg a, logic [31:0] d);
        cfg_we <= 1;
        cfg_addr <= a;
        cfg_data <= d;
        @(posedge i_clk);
    endtask

    // registers change only with the block idle
    task automatic drain();
        push <= 0;
        @(posedge i_clk);
        while (awaiting != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic set_config(logic lo, logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                              logic [31:0] sx, logic [31:0] sy, logic [31:0] sz);
        write_reg(CFG_LOCAL_ONLY, 32'(lo));
        write_reg(CFG_ANGLE_X, ax);
        write_reg(CFG_ANGLE_Y, ay);
        write_reg(CFG_ANGLE_Z, az);
        write_reg(CFG_SHIFT_X, sx);
        write_reg(CFG_SHIFT_Y, sy);
        write_reg(CFG_SHIFT_Z, sz);
        cfg_we <= 0;
    endtask

    function automatic logic [31:0] rand_angle();
        return 32'($signed($urandom_range(411774)) - 205887);
    endfunction

    // one random beat; returns 1 when the block does something with it
    task automatic random_beat(output bit counted);
        logic [5:0] v, n;
        logic [3:0] sl;
        int sel, tries;
        sel = $urandom_range(99);
        v = $urandom_range(63);
        counted = 1;
        if (sel < 5) begin
            // noise: out-of-range word or slot, ignored by the block
            sl = $urandom_range(1) ? 4'($urandom_range(15, 12)) : 4'($urandom_range(15, NK));
            send_beat(sl >= 12 ? MODE_NODE_WORD : MODE_NEIGHBOUR, v, sl,
                      $urandom_range(63), $urandom, $urandom, $urandom, rand_weight());
            counted = 0;
        end else if (sel < 15) begin
            send_beat(MODE_VERTEX, v, $urandom_range(15), $urandom_range(63),
                      rand_coord(), rand_coord(), rand_coord(), $urandom_range(131071));
        end else if (sel < 40) begin
            // node words mostly into a small pool so nodes become usable early
            n = ($urandom_range(3) != 0) ? 6'($urandom_range(15)) : v;
            sl = $urandom_range(11);
            send_beat(MODE_NODE_WORD, n, sl, $urandom_range(63), rand_word(sl),
                      $urandom, $urandom, $urandom_range(131071));
        end else if (sel < 60) begin
            tries = 0;
            n = $urandom_range(63);
            while (!node_ready(n) && tries < 20) begin
                n = $urandom_range(63);
                tries++;
            end
            send_beat(MODE_NEIGHBOUR, v, $urandom_range(NK - 1), n, $urandom, $urandom,
                      $urandom, node_ready(n) ? rand_weight() : 17'd0);
        end else begin
            tries = 0;
            while (!can_compute(v) && tries < 20) begin
                v = $urandom_range(63);
                tries++;
            end
            if (can_compute(v))
                send_beat(MODE_COMPUTE, v, $urandom_range(15), $urandom_range(63),
                          $urandom, $urandom, $urandom, $urandom_range(131071));
            else
                send_beat(MODE_VERTEX, v, 0, 0, rand_coord(), rand_coord(), rand_coord(), 0);
        end
    endtask

    initial begin
        int done;
        bit counted;
        for (int v = 0; v < NV; v++)
            for (int k = 0; k < NK; k++) begin
                tb_node[v][k] = 0;
                tb_w[v][k] = 0;
            end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: rails, every mode, zero and full weight, ignored slots
        set_config(1'b1, 0, 0, 0, 0, 0, 0);
        send_beat(MODE_VERTEX, 0, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000, 0);
        send_beat(MODE_VERTEX, 1, 0, 0, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_0000, 0);
        send_beat(MODE_VERTEX, 63, 15, 63, 32'h0002_8000, 32'hfffe_0000, 0, 17'h1ffff);
        for (int i = 0; i < 12; i++)
            send_beat(MODE_NODE_WORD, 1, i, 0,
                      (i == 0 || i == 4 || i == 8) ? 32'h0001_0000 :
                      (i == 9) ? 32'h7fff_ffff : (i == 11) ? 32'h8000_0000 : 32'h0,
                      0, 0, 0);
        send_beat(MODE_NODE_WORD, 1, 15, 0, 32'hdead_beef, 0, 0, 0);
        send_beat(MODE_NEIGHBOUR, 0, 0, 1, 0, 0, 0, 17'd65536);
        send_beat(MODE_NEIGHBOUR, 0, 1, 1, 0, 0, 0, 17'd0);
        send_beat(MODE_NEIGHBOUR, 0, 15, 63, 0, 0, 0, 17'd65536);
        send_beat(MODE_NEIGHBOUR, 63, 3, 1, 0, 0, 0, 17'd1);
        send_beat(MODE_COMPUTE, 0, 0, 0, 0, 0, 0, 0);
        send_beat(MODE_COMPUTE, 1, 0, 0, 0, 0, 0, 0);
        send_beat(MODE_COMPUTE, 63, 0, 0, 0, 0, 0, 0);

        // random phases, each with its own settings and idle pattern
        for (int ph = 0; ph < 8; ph++) begin
            // sender holds off until every result is back
            drain();
            case (ph)
                0: set_config(0, 0, 0, 0, 0, 0, 0);
                1: set_config(0, 205887, 205887, 205887,
                              32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
                2: set_config(0, -205887, -205887, -205887,
                              32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
                3: set_config(1, rand_angle(), rand_angle(), rand_angle(),
                              $urandom, $urandom, $urandom);
                default: set_config($urandom_range(3) != 0 ? 1'b0 : 1'b1,
                                    rand_angle(), rand_angle(), rand_angle(),
                                    32'($signed($urandom_range(1 << 22)) - (1 << 21)),
                                    $urandom, 32'($signed($urandom_range(1 << 22)) - (1 << 21)));
            endcase
            case (ph % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 67; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 67; end
                default: begin tx_idle_pct = 35; rx_stall_pct = 35; end
            endcase
            done = 0;
            while (done < 142) begin
                random_beat(counted);
                if (counted)
                    done++;
            end
        end

        drain();
        if (fail_count == 0)
            $display("embedded_graph_vertex_deform_core verification clean");
        else
            $display("embedded_graph_vertex_deform_core verification failed");
        $finish;
    end

endmodule

`default_nettype wire
